>>> sv/mqbf_pkg.sv
// ----------------------------------------------------------------------------
// mqbf_pkg
// Types, codes and constants shared by the multi-queue byte FIFO modules.
// ----------------------------------------------------------------------------
package mqbf_pkg;

  // Default configuration: four queues of 1024 bytes each.
  localparam int QUEUES_DEF = 4;
  localparam int DEPTH_DEF  = 1024;

  // Fixed field widths of the transaction ports.
  localparam int QUEUE_W   = 2;
  localparam int BYTE_W    = 8;
  localparam int FCOUNT_W  = 11;
  localparam int QUOT_W    = 7;

  // Fill percentage scale.
  localparam int PERCENT_SCALE = 100;

  // Operation codes on the kind field.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

>>> sv/mqbf_ram.sv
// ----------------------------------------------------------------------------
// mqbf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mqbf_ram #(
  parameter int WIDTH = 8,
  parameter int WORDS = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [WORDS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/mqbf_dp.sv
// ----------------------------------------------------------------------------
// mqbf_dp
// Datapath: queue pointers and counts, byte store, fill percentage and the
// output register.
// ----------------------------------------------------------------------------
module mqbf_dp
  import mqbf_pkg::*;
#(
  parameter int QUEUES = QUEUES_DEF,
  parameter int DEPTH  = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_kind,
  input  logic [QUEUE_W-1:0]  in_queue,
  input  logic [BYTE_W-1:0]   in_data_in,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          sts,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_status,
  output logic [BYTE_W-1:0]   out_data_out,
  output logic [FCOUNT_W-1:0] out_fill_count,
  output logic [QUOT_W-1:0]   out_fill_percent
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int ADDR_W = $clog2(QUEUES * DEPTH);

  // The percentage is count*100/DEPTH taken as a multiplication by the
  // rounded-up reciprocal. With the shift chosen so that its power of two
  // is at least DEPTH squared, the floor is exact for every count up to DEPTH.
  localparam int     PCT_SHIFT = 2 * PTR_W + 1;
  localparam longint PCT_MUL   = ((longint'(PERCENT_SCALE) << PCT_SHIFT) +
                                  longint'(DEPTH - 1)) / longint'(DEPTH);
  localparam int     MUL_W     = $clog2(PCT_MUL + 1);
  localparam int     PROD_W    = CNT_W + MUL_W;

  // Captured input transaction.
  logic               kind_r;
  logic [QUEUE_W-1:0] queue_r;
  logic [BYTE_W-1:0]  data_r;

  // Per-queue ring state.
  logic [PTR_W-1:0] wp_r  [QUEUES];
  logic [PTR_W-1:0] rp_r  [QUEUES];
  logic [CNT_W-1:0] cnt_r [QUEUES];

  // Operation result and percentage.
  logic              ok_r;
  logic              pop_ok_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic [QUOT_W-1:0] quot_r;

  // Output register.
  logic                out_valid_r;
  logic                out_status_r;
  logic [BYTE_W-1:0]   out_data_r;
  logic [FCOUNT_W-1:0] out_cnt_r;
  logic [QUOT_W-1:0]   out_pct_r;

  logic              q_ok;
  logic [QIDX_W-1:0] qi;
  logic [PTR_W-1:0]  cur_wp;
  logic [PTR_W-1:0]  cur_rp;
  logic [CNT_W-1:0]  cur_cnt;
  logic              push_ok;
  logic              pop_ok;
  logic [CNT_W-1:0]  new_cnt;
  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              ram_we;
  logic              ram_re;
  logic [PROD_W-1:0] pct_prod;
  logic              out_take;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_kind;
      queue_r <= in_queue;
      data_r  <= in_data_in;
    end
  end

  // Queues beyond the configured number are refused without touching state.
  always_comb begin
    q_ok    = int'(queue_r) < QUEUES;
    qi      = q_ok ? QIDX_W'(queue_r) : '0;
    cur_wp  = wp_r[qi];
    cur_rp  = rp_r[qi];
    cur_cnt = cnt_r[qi];
    push_ok = q_ok && (kind_r == KIND_PUSH) && (cur_cnt != CNT_W'(DEPTH));
    pop_ok  = q_ok && (kind_r == KIND_POP) && (cur_cnt != '0);
    if (push_ok) begin
      new_cnt = cur_cnt + CNT_W'(1);
    end else if (pop_ok) begin
      new_cnt = cur_cnt - CNT_W'(1);
    end else if (q_ok) begin
      new_cnt = cur_cnt;
    end else begin
      new_cnt = '0;
    end
    wp_adv    = (cur_wp == PTR_W'(DEPTH - 1)) ? '0 : cur_wp + PTR_W'(1);
    rp_adv    = (cur_rp == PTR_W'(DEPTH - 1)) ? '0 : cur_rp + PTR_W'(1);
    base      = ADDR_W'(qi) * ADDR_W'(DEPTH);
    ram_waddr = base + ADDR_W'(cur_wp);
    ram_raddr = base + ADDR_W'(cur_rp);
    ram_we    = cmd.exec && push_ok;
    ram_re    = cmd.exec && pop_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUES; i++) begin
        wp_r[i]  <= '0;
        rp_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (push_ok) begin
        wp_r[qi]  <= wp_adv;
        cnt_r[qi] <= new_cnt;
      end else if (pop_ok) begin
        rp_r[qi]  <= rp_adv;
        cnt_r[qi] <= new_cnt;
      end
    end
  end

  mqbf_ram #(
    .WIDTH (BYTE_W),
    .WORDS (QUEUES * DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pct_prod = PROD_W'(res_cnt_r) * PROD_W'(PCT_MUL);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r      <= push_ok || pop_ok;
      pop_ok_r  <= pop_ok;
      res_cnt_r <= new_cnt;
    end else if (cmd.div_step) begin
      quot_r <= pct_prod[PCT_SHIFT +: QUOT_W];
    end
  end

  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= ok_r ? STATUS_OK : STATUS_REFUSED;
      out_data_r   <= pop_ok_r ? ram_rdata : '0;
      out_cnt_r    <= FCOUNT_W'(res_cnt_r);
      out_pct_r    <= quot_r;
    end
  end

  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data_out     = out_data_r;
  assign out_fill_count   = out_cnt_r;
  assign out_fill_percent = out_pct_r;

endmodule

>>> sv/mqbf_ctrl.sv
// ----------------------------------------------------------------------------
// mqbf_ctrl
// Controller: sequences accept, queue update, percentage step and result load.
// ----------------------------------------------------------------------------
module mqbf_ctrl
  import mqbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_LOAD: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> sv/multi_queue_byte_fifo_top.sv
// ----------------------------------------------------------------------------
// multi_queue_byte_fifo_top
// Several byte FIFOs kept as ring buffers in one shared byte store.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one transaction: a push of
// in_data_in or a pop, addressed to queue in_queue. The result channel
// (out_valid, out_stall) returns exactly one transaction per input: status,
// popped byte, fill count after the operation and fill percentage.
// An input is taken in the idle state; the queue update follows, then the
// fill percentage is formed as a multiplication by a constant reciprocal
// of the depth, and last the output register is loaded. The next input is
// taken only after that load, back in the idle state, so one transaction
// is in flight at a time. The controller's four-state sequence sets this.
// A new input is accepted while the previous result still waits in the
// output register; if out_stall is still high when the next result is
// ready, the block holds it and keeps in_stall high until the output
// register frees. Synchronous reset empties all queues; the byte store
// itself is not cleared, as no entry is read before it is written.
// ----------------------------------------------------------------------------
module multi_queue_byte_fifo_top
  import mqbf_pkg::*;
#(
  parameter int QUEUES = QUEUES_DEF,
  parameter int DEPTH  = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [QUEUE_W-1:0]  in_queue,
  input  logic [BYTE_W-1:0]   in_data_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_status,
  output logic [BYTE_W-1:0]   out_data_out,
  output logic [FCOUNT_W-1:0] out_fill_count,
  output logic [QUOT_W-1:0]   out_fill_percent
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  mqbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mqbf_dp #(
    .QUEUES (QUEUES),
    .DEPTH  (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_queue         (in_queue),
    .in_data_in       (in_data_in),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_data_out     (out_data_out),
    .out_fill_count   (out_fill_count),
    .out_fill_percent (out_fill_percent)
  );

`ifndef ASSERT_OFF
  // Only one transaction is in flight: after an accept the input stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction was in flight");

  // A nonzero byte is only returned by an accepted pop.
  a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data_out != '0)) |-> (out_status == STATUS_OK))
    else $error("refused transaction returned data");

  // The fill percentage never exceeds the full scale.
  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_percent <= QUOT_W'(PERCENT_SCALE)))
    else $error("fill percentage out of range");

  // The percentage step always directly follows the queue update.
  a_step_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> cmd.div_step)
    else $error("percentage step did not follow the queue update");
`endif

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: multi-queue byte FIFO testbench
// A shadow copy of the four ring buffers predicts the status, popped byte,
// fill count and fill percentage of every transaction. Each result is checked
// field by field, in order. A short directed sequence runs first. Random
// traffic follows, and in that traffic one queue is driven to full and then
// partly drained. The sender works in bursts and gaps. The receiver cycles
// through several stall patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mqbf_pkg::*;

  localparam int QUEUES       = QUEUES_DEF;
  localparam int DEPTH        = DEPTH_DEF;
  localparam int N_ITEMS      = 1900;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic               kind;
    logic [QUEUE_W-1:0] queue;
    logic [BYTE_W-1:0]  data;
  } fifo_op_t;

  typedef struct {
    logic                status;
    logic [BYTE_W-1:0]   data;
    logic [FCOUNT_W-1:0] fill;
    logic [QUOT_W-1:0]   pct;
  } fifo_resp_t;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_kind = KIND_PUSH;
  logic [QUEUE_W-1:0]  in_queue = '0;
  logic [BYTE_W-1:0]   in_data_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_status;
  logic [BYTE_W-1:0]   out_data_out;
  logic [FCOUNT_W-1:0] out_fill_count;
  logic [QUOT_W-1:0]   out_fill_percent;

  multi_queue_byte_fifo_top #(
    .QUEUES(QUEUES),
    .DEPTH (DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_queue        (in_queue),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_fill_count  (out_fill_count),
    .out_fill_percent(out_fill_percent)
  );

  // Shadow copy of the ring buffers.
  logic [BYTE_W-1:0] ring_mem [QUEUES*DEPTH];
  int unsigned       wr_ptr [QUEUES];
  int unsigned       rd_ptr [QUEUES];
  int unsigned       held [QUEUES];

  // Fill levels seen while the stimulus is generated, used to steer it.
  int unsigned       gen_held [QUEUES];

  fifo_op_t          op_pending [$];
  fifo_resp_t        resp_expected [$];

  logic              op_taken = 1'b0;
  int unsigned       gap_left = 0;
  int unsigned       burst_left = 0;
  int unsigned       stall_left = 0;
  rx_mode_t          stall_mode = RX_OPEN;
  int unsigned       cycle_cnt = 0;
  int unsigned       n_errors = 0;
  int unsigned       n_sent = 0;
  int unsigned       n_checked = 0;
  int unsigned       n_full_refused = 0;
  int unsigned       n_empty_refused = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  function automatic fifo_resp_t apply_op(fifo_op_t op);
    fifo_resp_t  r;
    int unsigned q;
    int unsigned cnt;
    q = 32'(op.queue);
    r.status = STATUS_REFUSED;
    r.data = '0;
    cnt = 0;
    if (q < QUEUES) begin
      if (op.kind == KIND_PUSH) begin
        if (held[q] < DEPTH) begin
          ring_mem[q*DEPTH + wr_ptr[q]] = op.data;
          wr_ptr[q] = (wr_ptr[q] + 1 == DEPTH) ? 0 : wr_ptr[q] + 1;
          held[q]++;
          r.status = STATUS_OK;
        end
      end else if (held[q] != 0) begin
        r.data = ring_mem[q*DEPTH + rd_ptr[q]];
        rd_ptr[q] = (rd_ptr[q] + 1 == DEPTH) ? 0 : rd_ptr[q] + 1;
        held[q]--;
        r.status = STATUS_OK;
      end
      cnt = held[q];
    end
    r.fill = FCOUNT_W'(cnt);
    r.pct = QUOT_W'((cnt * PERCENT_SCALE) / DEPTH);
    return r;
  endfunction

  task automatic add_op(input logic kind, input int unsigned q, input logic [BYTE_W-1:0] d);
    fifo_op_t op;
    op.kind = kind;
    op.queue = QUEUE_W'(q);
    op.data = d;
    if (kind == KIND_PUSH && gen_held[q] < DEPTH) begin
      gen_held[q]++;
    end else if (kind == KIND_POP && gen_held[q] != 0) begin
      gen_held[q]--;
    end
    op_pending.push_back(op);
  endtask

  task automatic add_random_op(input int unsigned pop_pct);
    add_op(($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_PUSH,
           $urandom_range(0, QUEUES-1), BYTE_W'($urandom_range(0, 255)));
  endtask

  // Sender: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !op_taken)) begin
      op_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_pending.size() > 0) begin
        in_kind    <= op_pending[0].kind;
        in_queue   <= op_pending[0].queue;
        in_data_in <= op_pending[0].data;
        in_valid   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          burst_left = $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // An accepted transaction is predicted at the edge where it is taken.
  always @(posedge clk) begin : take_ops
    fifo_op_t op;
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      op = op_pending.pop_front();
      resp_expected.push_back(apply_op(op));
      op_taken = 1'b1;
      n_sent++;
    end
  end

  // Receiver: the stall pattern changes character in turn, chosen from the cycle count.
  always @(negedge clk) begin : rx_stall
    logic nxt;
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'((cycle_cnt / 1500) % 4);
      case (stall_mode)
        RX_OPEN: begin
          nxt = 1'b0;
          stall_left = $urandom_range(1, 50);
        end
        RX_CHOPPY: begin
          nxt = 1'($urandom_range(0, 1));
          stall_left = $urandom_range(1, 4);
        end
        RX_HEAVY: begin
          nxt = ($urandom_range(0, 9) < 7);
          stall_left = $urandom_range(1, 12);
        end
        default: begin
          nxt = !out_stall;
          stall_left = 1;
        end
      endcase
      out_stall <= nxt;
    end
    stall_left--;
  end

  always @(posedge clk) begin : check_results
    fifo_resp_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (resp_expected.size() == 0) begin
        report_mismatch("result with nothing pending, fill_count", 32'(out_fill_count), 0);
      end else begin
        want = resp_expected.pop_front();
        n_checked++;
        if (want.status == STATUS_REFUSED && want.fill == DEPTH) n_full_refused++;
        if (want.status == STATUS_REFUSED && want.fill == 0) n_empty_refused++;
        if (out_status !== want.status) begin
          report_mismatch("status", 32'(out_status), 32'(want.status));
        end
        if (out_data_out !== want.data) begin
          report_mismatch("data_out", 32'(out_data_out), 32'(want.data));
        end
        if (out_fill_count !== want.fill) begin
          report_mismatch("fill_count", 32'(out_fill_count), 32'(want.fill));
        end
        if (out_fill_percent !== want.pct) begin
          report_mismatch("fill_percent", 32'(out_fill_percent), 32'(want.pct));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d transactions unsent, %0d results missing",
               cycle_cnt, op_pending.size(), resp_expected.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    // Directed: pops from empty queues, extreme bytes, then back to empty.
    for (int q = 0; q < QUEUES; q++) add_op(KIND_POP, q, 8'hFF);
    add_op(KIND_PUSH, 0, 8'h00);
    add_op(KIND_PUSH, 3, 8'hFF);
    add_op(KIND_PUSH, 1, 8'hAA);
    add_op(KIND_PUSH, 2, 8'h55);
    add_op(KIND_PUSH, 1, 8'h01);
    add_op(KIND_POP, 0, 8'h00);
    add_op(KIND_POP, 3, 8'h00);
    add_op(KIND_POP, 1, 8'h3C);
    add_op(KIND_POP, 2, 8'hC3);
    add_op(KIND_POP, 1, 8'h00);
    add_op(KIND_POP, 2, 8'h00);
    add_op(KIND_POP, 1, 8'hFF);

    // Random traffic, then a long fill of one queue until pushes are refused.
    repeat (300) add_random_op(50);
    target = $urandom_range(0, QUEUES-1);
    while (gen_held[target] < DEPTH) begin
      if ($urandom_range(0, 99) < 88) begin
        add_op(KIND_PUSH, target, BYTE_W'($urandom_range(0, 255)));
      end else begin
        add_random_op(50);
      end
    end
    repeat (5) add_op(KIND_PUSH, target, BYTE_W'($urandom_range(0, 255)));
    // Pop-heavy traffic to bring the full queue back down.
    while (op_pending.size() < N_ITEMS) begin
      if ($urandom_range(0, 99) < 30) begin
        add_op(KIND_POP, target, BYTE_W'($urandom_range(0, 255)));
      end else begin
        add_random_op(60);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (op_pending.size() != 0 || resp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions over %0d queues and checked %0d results.",
             n_sent, QUEUES, n_checked);
    $display("Refused: %0d pushes into a full queue, %0d pops from an empty one; %0d errors.",
             n_full_refused, n_empty_refused, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> multi_queue_byte_fifo_top.f
sv/mqbf_pkg.sv
sv/mqbf_ram.sv
sv/mqbf_dp.sv
sv/mqbf_ctrl.sv
sv/multi_queue_byte_fifo_top.sv
dv/tb.sv
